// File: design/message_whitespace_cleanup_core_assert.svh
// Assertion macros shared by the cleanup core modules.
`ifndef MESSAGE_WHITESPACE_CLEANUP_CORE_ASSERT_SVH
`define MESSAGE_WHITESPACE_CLEANUP_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mws_pkg;

  // Whitespace buffer geometry.
  localparam int WS_DEPTH = 32;
  localparam int CNT_W    = $clog2(WS_DEPTH + 1);
  localparam int ADDR_W   = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  // Byte codes.
  localparam logic [7:0] NL_BYTE       = 8'h0A;
  localparam logic [7:0] SPACE_BYTE    = 8'h20;
  localparam logic [7:0] TAB_BYTE      = 8'h09;
  localparam logic [7:0] VT_BYTE       = 8'h0B;
  localparam logic [7:0] FF_BYTE       = 8'h0C;
  localparam logic [7:0] CR_BYTE       = 8'h0D;
  localparam logic [7:0] MARKER_RESET  = 8'd35;

  // Configuration register indexes.
  localparam logic CFG_STRIP  = 1'b0;
  localparam logic CFG_MARKER = 1'b1;

  // Work plan for one accepted request, in emission order.
  typedef struct packed {
    logic             blank;      // separator newline before the text
    logic [CNT_W-1:0] flush_cnt;  // buffered whitespace to replay
    logic             main;       // the byte itself, or a line newline
    logic [7:0]       main_byte;
    logic             endnl;      // newline closing an unfinished line
    logic             quiet;      // end marker with no byte
    logic             done;
    logic             ovf;
  } plan_t;

  // One result toward the output register.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       done;
    logic       ovf;
  } res_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == SPACE_BYTE) || (b == TAB_BYTE) || (b == VT_BYTE) ||
               (b == FF_BYTE) || (b == CR_BYTE);
  endfunction

endpackage

`default_nettype wire

// File: design/mws_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read that holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/mws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "message_whitespace_cleanup_core_assert.svh"

module mws_ctrl
  import mws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic [7:0]        in_byte,
  input  wire logic              byte_present,
  input  wire logic              end_of_message,
  input  wire logic              accept,
  output plan_t                  plan,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [7:0]        wr_data
);

  logic             strip_comment_lines;
  logic [7:0]       comment_marker;

  logic             at_line_start, at_line_start_next;
  logic             skipping_comment, skipping_comment_next;
  logic             line_has_text, line_has_text_next;
  logic             blank_pending, blank_pending_next;
  logic             output_started, output_started_next;
  logic [CNT_W-1:0] pending_count, pending_count_next;
  logic             overflow_seen, overflow_seen_next;
  logic             ws_write;
  logic             is_nl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_comment_lines <= 1'b0;
      comment_marker      <= MARKER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STRIP:  strip_comment_lines <= cfg_data[0];
        CFG_MARKER: comment_marker      <= cfg_data;
        default:    strip_comment_lines <= strip_comment_lines;
      endcase
    end
  end

  // Line state update and work plan for the request on the input.
  always_comb begin
    at_line_start_next    = at_line_start;
    skipping_comment_next = skipping_comment;
    line_has_text_next    = line_has_text;
    blank_pending_next    = blank_pending;
    output_started_next   = output_started;
    pending_count_next    = pending_count;
    overflow_seen_next    = overflow_seen;
    ws_write              = 1'b0;
    plan                  = '0;
    is_nl                 = (in_byte == NL_BYTE);

    if (byte_present) begin
      if (at_line_start && strip_comment_lines && (in_byte == comment_marker)) begin
        // A comment line starts; a newline marker drops just that newline.
        if (!is_nl) begin
          skipping_comment_next = 1'b1;
          at_line_start_next    = 1'b0;
        end
      end else if (skipping_comment) begin
        if (is_nl) begin
          skipping_comment_next = 1'b0;
          at_line_start_next    = 1'b1;
        end
      end else if (is_nl) begin
        if (line_has_text) begin
          plan.main      = 1'b1;
          plan.main_byte = NL_BYTE;
        end else begin
          blank_pending_next = 1'b1;
        end
        line_has_text_next = 1'b0;
        pending_count_next = '0;
        at_line_start_next = 1'b1;
      end else if (is_blank(in_byte)) begin
        at_line_start_next = 1'b0;
        if (pending_count < CNT_W'(WS_DEPTH)) begin
          ws_write           = 1'b1;
          pending_count_next = pending_count + CNT_W'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end else begin
        // Text byte: separator, replayed whitespace, then the byte.
        at_line_start_next = 1'b0;
        if (!line_has_text) begin
          plan.blank         = blank_pending && output_started;
          blank_pending_next = 1'b0;
        end
        plan.flush_cnt      = pending_count;
        pending_count_next  = '0;
        plan.main           = 1'b1;
        plan.main_byte      = in_byte;
        line_has_text_next  = 1'b1;
        output_started_next = 1'b1;
      end
    end

    plan.ovf = overflow_seen_next;

    if (end_of_message) begin
      plan.done  = 1'b1;
      plan.endnl = !skipping_comment_next && line_has_text_next;
      plan.quiet = !(plan.blank || (plan.flush_cnt != '0) || plan.main || plan.endnl);
      at_line_start_next    = 1'b1;
      skipping_comment_next = 1'b0;
      line_has_text_next    = 1'b0;
      blank_pending_next    = 1'b0;
      output_started_next   = 1'b0;
      pending_count_next    = '0;
      overflow_seen_next    = 1'b0;
    end
  end

  // Whitespace goes to the buffer at the current fill position.
  assign wr_en   = accept && ws_write;
  assign wr_addr = pending_count[ADDR_W-1:0];
  assign wr_data = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start    <= 1'b1;
      skipping_comment <= 1'b0;
      line_has_text    <= 1'b0;
      blank_pending    <= 1'b0;
      output_started   <= 1'b0;
      pending_count    <= '0;
      overflow_seen    <= 1'b0;
    end else if (accept) begin
      at_line_start    <= at_line_start_next;
      skipping_comment <= skipping_comment_next;
      line_has_text    <= line_has_text_next;
      blank_pending    <= blank_pending_next;
      output_started   <= output_started_next;
      pending_count    <= pending_count_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

  `MWS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, pending_count <= CNT_W'(WS_DEPTH), "pending count beyond buffer depth")
  `MWS_ASSERT_NOW(a_comment_no_text, clk, rst, skipping_comment, !line_has_text && (pending_count == '0), "text state held inside a comment line")

endmodule

`default_nettype wire

// File: design/mws_seq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "message_whitespace_cleanup_core_assert.svh"

module mws_seq
  import mws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_valid,
  input  wire plan_t             plan,
  input  wire logic              out_ready,
  input  wire logic [7:0]        rd_data,
  output logic                   s_ready,
  output logic                   accept,
  output logic                   rd_en,
  output logic      [ADDR_W-1:0] rd_addr,
  output logic                   res_valid,
  output res_t                   res
);

  seq_state_t       state, state_next;
  logic [CNT_W-1:0] flush_left, flush_left_next;
  logic [ADDR_W-1:0] flush_idx, flush_idx_next;
  logic             main_q, main_q_next;
  logic [7:0]       main_byte_q, main_byte_q_next;
  logic             endnl_q, endnl_q_next;
  logic             done_q, done_q_next;
  logic             ovf_q, ovf_q_next;

  logic             take_main, take_end, has_flush, rem_any;
  logic             run_last;

  // Which part of the plan goes out in the accept cycle.
  always_comb begin
    has_flush = (plan.flush_cnt != '0);
    take_main = !plan.blank && !has_flush && plan.main;
    take_end  = !plan.blank && !has_flush && !plan.main && plan.endnl;
    rem_any   = has_flush || (plan.main && !take_main) || (plan.endnl && !take_end);
    run_last  = (flush_left > CNT_W'(1)) ? 1'b0 :
                (flush_left == CNT_W'(1)) ? (!main_q && !endnl_q) :
                main_q ? !endnl_q : 1'b1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (accept && rem_any) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (out_ready && run_last) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Outputs and working registers.
  always_comb begin
    s_ready          = (state == SEQ_IDLE) && out_ready;
    accept           = s_ready && s_valid;
    rd_en            = 1'b0;
    rd_addr          = '0;
    res_valid        = 1'b0;
    res              = '0;
    flush_left_next  = flush_left;
    flush_idx_next   = flush_idx;
    main_q_next      = main_q;
    main_byte_q_next = main_byte_q;
    endnl_q_next     = endnl_q;
    done_q_next      = done_q;
    ovf_q_next       = ovf_q;

    unique case (state)
      SEQ_IDLE: begin
        if (accept) begin
          // Prefetch the first buffered byte in case a replay follows.
          rd_en            = 1'b1;
          rd_addr          = '0;
          flush_left_next  = plan.flush_cnt;
          flush_idx_next   = '0;
          main_q_next      = plan.main && !take_main;
          main_byte_q_next = plan.main_byte;
          endnl_q_next     = plan.endnl && !take_end;
          done_q_next      = plan.done;
          ovf_q_next       = plan.ovf;
          res_valid        = plan.blank || take_main || take_end || plan.quiet;
          res.valid        = !plan.quiet;
          res.data         = plan.quiet ? 8'h00 : (take_main ? plan.main_byte : NL_BYTE);
          res.last         = !rem_any;
          res.done         = plan.done && !rem_any;
          res.ovf          = plan.ovf;
        end
      end
      SEQ_RUN: begin
        res_valid = 1'b1;
        res.valid = 1'b1;
        res.last  = run_last;
        res.done  = done_q && run_last;
        res.ovf   = ovf_q;
        if (flush_left != '0) begin
          res.data = rd_data;
          if (out_ready) begin
            flush_left_next = flush_left - CNT_W'(1);
            flush_idx_next  = flush_idx + ADDR_W'(1);
            rd_en           = (flush_left > CNT_W'(1));
            rd_addr         = flush_idx + ADDR_W'(1);
          end
        end else if (main_q) begin
          res.data = main_byte_q;
          if (out_ready) begin
            main_q_next = 1'b0;
          end
        end else begin
          res.data = NL_BYTE;
          if (out_ready) begin
            endnl_q_next = 1'b0;
          end
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      flush_left <= '0;
      main_q     <= 1'b0;
      endnl_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state      <= state_next;
      flush_left <= flush_left_next;
      main_q     <= main_q_next;
      endnl_q    <= endnl_q_next;
      done_q     <= done_q_next;
    end
  end

  always_ff @(posedge clk) begin
    flush_idx   <= flush_idx_next;
    main_byte_q <= main_byte_q_next;
    ovf_q       <= ovf_q_next;
  end

  `MWS_ASSERT_NOW(a_run_has_work, clk, rst, state == SEQ_RUN, (flush_left != '0) || main_q || endnl_q, "sequencer busy with nothing left")
  `MWS_ASSERT_NOW(a_done_is_last, clk, rst, res_valid && res.done, res.last, "message end not on the last result")
  `MWS_ASSERT_NEXT(a_last_ends_run, clk, rst, (state == SEQ_RUN) && out_ready && run_last, state == SEQ_IDLE, "sequencer did not return after last result")
  `MWS_ASSERT_NOW(a_result_room, clk, rst, res_valid, out_ready || (state == SEQ_RUN), "result offered without room")

endmodule

`default_nettype wire

// File: design/mws_out.sv
`timescale 1ns / 1ps
`default_nettype none

module mws_out
  import mws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       res_valid,
  input  wire res_t       res,
  output logic            res_ready,
  output logic            m_valid,
  input  wire logic       m_ready,
  output logic [7:0]      m_data,
  output logic            m_last,
  output logic [2:0]      m_user
);

  res_t hold;

  // The register takes a new result when it is empty or being drained.
  assign res_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (res_ready) begin
      m_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      hold <= res;
    end
  end

  assign m_data = hold.data;
  assign m_last = hold.last;
  assign m_user = {hold.ovf, hold.done, hold.valid};

endmodule

`default_nettype wire

// File: design/message_whitespace_cleanup_core.sv
// Message whitespace cleanup core.
// Input stream s_axis: one request per message byte. tdata carries the byte,
// tuser says whether a byte is present, tlast marks the last request of a
// message. Output stream m_axis: tdata is the cleaned byte, tuser[0] says a
// byte is present (0 for a bare end marker), tuser[1] marks the end of the
// message, tuser[2] flags dropped whitespace, tlast closes each request.
// Config port: cfg_index 0 = strip comment lines, 1 = comment marker, always
// ready. Users must write it only while idle; the core does not enforce it.
// A result is registered and appears on m_axis in the cycle after its request
// is taken; a replayed whitespace byte first passes the buffer read register,
// then the output register.
// Throughput: one request per cycle when it yields at most one result and
// m_axis does not stall; a request with more results holds the input until
// its last result is taken, and one that replays buffered whitespace with no
// separator newline in front yields nothing while the buffer read is made.
// Reset clears the line state and the config registers; the whitespace
// buffer needs no clearing pass. When m_axis stalls, the output register
// holds its result and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none

module message_whitespace_cleanup_core
  import mws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte
  input  wire logic       s_axis_tuser,   // byte_present
  input  wire logic       s_axis_tlast,   // end_of_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [2:0]      m_axis_tuser,   // out_valid, message_done, whitespace_overflow
  output logic            m_axis_tlast,   // last_of_run
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  plan_t             plan;
  res_t              res;
  logic              accept;
  logic              res_valid;
  logic              res_ready;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Line state, config registers and per-request plan.
  mws_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_byte        (s_axis_tdata),
    .byte_present   (s_axis_tuser),
    .end_of_message (s_axis_tlast),
    .accept         (accept),
    .plan           (plan),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  // Buffer for whitespace that may still turn out to be trailing.
  mws_ram #(
    .WIDTH (8),
    .DEPTH (WS_DEPTH)
  ) u_ws_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result sequencer.
  mws_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .plan      (plan),
    .out_ready (res_ready),
    .rd_data   (rd_data),
    .s_ready   (s_axis_tready),
    .accept    (accept),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register toward the receiver.
  mws_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_axis_tdata),
    .m_last    (m_axis_tlast),
    .m_user    (m_axis_tuser)
  );

endmodule

`default_nettype wire
